[design/hsvl_pkg.sv]
// ----------------------------------------------------------------------------
// hsvl_pkg
// Shared types and constants for the HSV color table entry block.
// ----------------------------------------------------------------------------
package hsvl_pkg;

  localparam logic [15:0] SAT_Q16    = 16'd64881;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_BIAS    = 3'd0,
    REG_HUE_STEP    = 3'd1,
    REG_VALUE_FLOOR = 3'd2,
    REG_RED_GAIN    = 3'd3,
    REG_GREEN_GAIN  = 3'd4,
    REG_BLUE_GAIN   = 3'd5,
    REG_BRIGHT_CAP  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [18:0] hue_bias;
    logic [15:0]        hue_step;
    logic [7:0]         value_floor;
    logic [9:0]         red_gain;
    logic [9:0]         green_gain;
    logic [9:0]         blue_gain;
    logic [9:0]         brightness_cap;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [2:0]  sextant;
    logic [15:0] frac;
    logic [15:0] v;
  } cls_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       capped;
  } pix_t;

endpackage

[design/hsvl_front.sv]
// ----------------------------------------------------------------------------
// hsvl_front
// Accepts indexes, computes hue sextant/fraction and value. Two stages.
// ----------------------------------------------------------------------------
module hsvl_front import hsvl_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_index,
  output logic       out_valid,
  input  logic       out_ready,
  output cls_t       out_cls
);

  // ceil(2^40 / ENTRIES): exact floor of dif*65536/ENTRIES for table sizes up to 65536
  localparam longint RECIP = ((longint'(1) << 40) + longint'(ENTRIES) - 1)
                             / longint'(ENTRIES);

  logic               s1_valid_r, s2_valid_r;
  logic [15:0]        hue_r;
  logic [15:0]        v_r;
  logic [18:0]        h6_r;
  logic [15:0]        v2_r;
  logic               adv1, adv2;
  logic signed [26:0] hs;
  logic [7:0]         dif;
  logic [48:0]        vq;
  logic [15:0]        v_nxt;

  assign adv2     = !s2_valid_r || out_ready;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;

  assign hs  = $signed({1'b0, 8'(in_index) * 24'(cfg.hue_step)}) + 27'(cfg.hue_bias);
  assign dif = in_index - cfg.value_floor;

  always_comb begin
    vq = 49'(dif) * 49'(RECIP);
    if (in_index <= cfg.value_floor) v_nxt = '0;
    else if (vq[48:24] > 25'd65535) v_nxt = 16'hFFFF;
    else v_nxt = vq[39:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
    if (adv1 && in_valid) begin
      hue_r <= hs[26] ? 16'd0 : hs[15:0];
      v_r   <= v_nxt;
    end
    if (adv2 && s1_valid_r) begin
      h6_r <= 19'(hue_r) * 19'd6;
      v2_r <= v_r;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_cls.sextant = h6_r[18:16];
  assign out_cls.frac    = h6_r[15:0];
  assign out_cls.v       = v2_r;

endmodule

[design/hsvl_fifo.sv]
// ----------------------------------------------------------------------------
// hsvl_fifo
// Four-entry queue between front and back.
// ----------------------------------------------------------------------------
module hsvl_fifo import hsvl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cls_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cls_t out_data
);

  cls_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign in_ready  = cnt_r != 3'd4;
  assign out_valid = cnt_r != 3'd0;
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
    if (wr) mem_r[wp_r] <= in_data;
  end

endmodule

[design/hsvl_div.sv]
// ----------------------------------------------------------------------------
// hsvl_div
// Pipelined restoring divider, 18-bit dividend by 10-bit divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module hsvl_div import hsvl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] num,
  input  logic [9:0]  den,
  output logic [7:0]  quo
);

  logic [17:0] n_r [17];
  logic [10:0] r_r [17];
  logic [9:0]  d_r [17];
  logic [7:0]  q_r [18];

  // quotient fits 8 bits whenever the brightness cap applies, so only the low 8 bits are kept
  for (genvar i = 0; i < 18; i++) begin : g_st
    logic [17:0] n_in;
    logic [10:0] r_in;
    logic [9:0]  d_in;
    logic [7:0]  q_in;
    logic [11:0] rs;
    logic [11:0] df;
    if (i == 0) begin : g_head
      assign n_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_tail
      assign n_in = n_r[i-1];
      assign r_in = r_r[i-1];
      assign d_in = d_r[i-1];
      assign q_in = q_r[i-1];
    end
    assign rs = {r_in, n_in[17-i]};
    assign df = rs - {2'd0, d_in};
    always_ff @(posedge clk) begin
      if (en) q_r[i] <= {q_in[6:0], !df[11]};
    end
    if (i < 17) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i] <= n_in;
          d_r[i] <= d_in;
          r_r[i] <= df[11] ? rs[10:0] : df[10:0];
        end
      end
    end
  end

  assign quo = q_r[17];

endmodule

[design/hsvl_back.sv]
// ----------------------------------------------------------------------------
// hsvl_back
// Builds p/q/t, picks channels, applies gains and the brightness cap.
// Enable-stalled pipeline with output register.
// ----------------------------------------------------------------------------
module hsvl_back import hsvl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  cls_t in_cls,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix
);

  localparam int DEPTH = 25;

  logic             en;
  logic [DEPTH-1:0] vld_r;

  // stage a: saturation times fraction
  logic [2:0]  a_sx_r;
  logic [15:0] a_v_r, a_sf_r, a_sg_r;
  // stage b: p q t
  logic [2:0]  b_sx_r;
  logic [15:0] b_v_r, b_p_r, b_q_r, b_t_r;
  // stage c: channel levels
  logic [15:0] c_r_r, c_g_r, c_b_r;
  logic [6:0]  d_r_r, d_g_r, d_b_r;
  logic [7:0]  e_r_r, e_g_r, e_b_r;
  logic [9:0]  f_tot_r;
  logic [9:0]  f_cap_r;
  logic        f_cp_r;
  logic [7:0]  f_r_r, f_g_r, f_b_r;
  logic [17:0] g_nr_r, g_ng_r, g_nb_r;
  logic [9:0]  g_tot_r;
  logic [7:0]  pr [19], pg [19], pb [19];
  logic        pc [19];
  logic [7:0]  qr, qg, qb;
  logic [31:0] sf, sg;
  logic [31:0] mp, mq, mt;
  logic [15:0] lr, lg, lb;
  logic [17:0] gr, gg, gb;
  pix_t        out_r;
  logic        ov_r;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;

  function automatic logic [7:0] sat8(input logic [17:0] x);
    sat8 = (x[17:8] > 10'd255) ? 8'd255 : x[15:8];
  endfunction

  assign sf = 32'(SAT_Q16) * 32'(in_cls.frac);
  assign sg = 32'(SAT_Q16) * (32'(ONE_Q16) - 32'(in_cls.frac));
  assign mp = 32'(a_v_r) * (32'(ONE_Q16) - 32'(SAT_Q16));
  assign mq = 32'(a_v_r) * (32'(ONE_Q16) - 32'(a_sf_r));
  assign mt = 32'(a_v_r) * (32'(ONE_Q16) - 32'(a_sg_r));

  always_comb begin
    case (b_sx_r)
      3'd0:    begin lr = b_v_r; lg = b_t_r; lb = b_p_r; end
      3'd1:    begin lr = b_q_r; lg = b_v_r; lb = b_p_r; end
      3'd2:    begin lr = b_p_r; lg = b_v_r; lb = b_t_r; end
      3'd3:    begin lr = b_p_r; lg = b_q_r; lb = b_v_r; end
      3'd4:    begin lr = b_t_r; lg = b_p_r; lb = b_v_r; end
      default: begin lr = b_v_r; lg = b_p_r; lb = b_q_r; end
    endcase
  end

  assign gr = 18'(d_r_r) * 18'(cfg.red_gain);
  assign gg = 18'(d_g_r) * 18'(cfg.green_gain);
  assign gb = 18'(d_b_r) * 18'(cfg.blue_gain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
      ov_r  <= vld_r[DEPTH-1];
    end
    if (en) begin
      a_sx_r <= in_cls.sextant;
      a_v_r  <= in_cls.v;
      a_sf_r <= sf[31:16];
      a_sg_r <= sg[31:16];
      b_sx_r <= a_sx_r;
      b_v_r  <= a_v_r;
      b_p_r  <= mp[31:16];
      b_q_r  <= mq[31:16];
      b_t_r  <= mt[31:16];
      c_r_r  <= lr;
      c_g_r  <= lg;
      c_b_r  <= lb;
      d_r_r  <= 7'((23'(c_r_r) * 23'd127) >> 16);
      d_g_r  <= 7'((23'(c_g_r) * 23'd127) >> 16);
      d_b_r  <= 7'((23'(c_b_r) * 23'd127) >> 16);
      e_r_r  <= sat8(gr);
      e_g_r  <= sat8(gg);
      e_b_r  <= sat8(gb);
      f_tot_r <= 10'(e_r_r) + 10'(e_g_r) + 10'(e_b_r);
      f_cap_r <= cfg.brightness_cap;
      f_cp_r  <= (10'(e_r_r) + 10'(e_g_r) + 10'(e_b_r)) > cfg.brightness_cap;
      f_r_r  <= e_r_r;
      f_g_r  <= e_g_r;
      f_b_r  <= e_b_r;
      g_nr_r <= 18'(f_r_r) * 18'(f_cap_r);
      g_ng_r <= 18'(f_g_r) * 18'(f_cap_r);
      g_nb_r <= 18'(f_b_r) * 18'(f_cap_r);
      g_tot_r <= f_tot_r;
      pr[0]  <= f_r_r;
      pg[0]  <= f_g_r;
      pb[0]  <= f_b_r;
      pc[0]  <= f_cp_r;
      for (int i = 0; i < 18; i++) begin
        pr[i+1] <= pr[i];
        pg[i+1] <= pg[i];
        pb[i+1] <= pb[i];
        pc[i+1] <= pc[i];
      end
      out_r.red    <= pc[18] ? qr : pr[18];
      out_r.green  <= pc[18] ? qg : pg[18];
      out_r.blue   <= pc[18] ? qb : pb[18];
      out_r.capped <= pc[18];
    end
  end

  hsvl_div u_div_r (.clk(clk), .en(en), .num(g_nr_r), .den(g_tot_r), .quo(qr));
  hsvl_div u_div_g (.clk(clk), .en(en), .num(g_ng_r), .den(g_tot_r), .quo(qg));
  hsvl_div u_div_b (.clk(clk), .en(en), .num(g_nb_r), .den(g_tot_r), .quo(qb));

  assign out_valid = ov_r;
  assign out_pix   = out_r;

endmodule

[design/hsv_color_lut_entry.sv]
// ----------------------------------------------------------------------------
// hsv_color_lut_entry
// Index to LED color: hue/value from index, HSV to RGB, gains, sum cap.
// ----------------------------------------------------------------------------
// Accepts one index per clock while out_tready is high and returns one color
// per index in order. From the accepting edge to out_tvalid an index passes two
// front stages, the four-entry queue and a 25-stage back pipeline whose length
// is set by the 18-stage cap divider. Throughput is one transaction per cycle
// while out_tready is high.
module hsv_color_lut_entry import hsvl_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // blue, green, red from MSB down
  output logic                  out_tuser   // capped
);

  cfg_t cfg_r;
  cls_t f_cls, q_cls;
  pix_t pix;
  logic f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_bias       <= '0;
      cfg_r.hue_step       <= 16'd256;
      cfg_r.value_floor    <= '0;
      cfg_r.red_gain       <= 10'd256;
      cfg_r.green_gain     <= 10'd256;
      cfg_r.blue_gain      <= 10'd256;
      cfg_r.brightness_cap <= 10'd765;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_BIAS:    cfg_r.hue_bias       <= cfg_data;
        REG_HUE_STEP:    cfg_r.hue_step       <= cfg_data[15:0];
        REG_VALUE_FLOOR: cfg_r.value_floor    <= cfg_data[7:0];
        REG_RED_GAIN:    cfg_r.red_gain       <= cfg_data[9:0];
        REG_GREEN_GAIN:  cfg_r.green_gain     <= cfg_data[9:0];
        REG_BLUE_GAIN:   cfg_r.blue_gain      <= cfg_data[9:0];
        REG_BRIGHT_CAP:  cfg_r.brightness_cap <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  hsvl_front #(.ENTRIES(ENTRIES)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_index(in_tdata),
    .out_valid(f_valid), .out_ready(f_ready), .out_cls(f_cls)
  );

  hsvl_fifo u_fifo (
    .clk, .rst_n,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cls),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cls)
  );

  hsvl_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(q_valid), .in_ready(q_ready), .in_cls(q_cls),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_pix(pix)
  );

  assign out_tdata = {pix.blue, pix.green, pix.red};
  assign out_tuser = pix.capped;

  a_cap_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (10'(out_tdata[7:0]) + 10'(out_tdata[15:8]) + 10'(out_tdata[23:16]))
        <= cfg_r.brightness_cap)
    else $error("capped color exceeds cap");

  a_no_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && !$past(cfg_we) |->
      (10'(out_tdata[7:0]) + 10'(out_tdata[15:8]) + 10'(out_tdata[23:16]))
        <= cfg_r.brightness_cap || $past(cfg_we, 2))
    else $error("uncapped color above cap");

endmodule

[tb/sv/hsv_color_lut_entry_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_color_lut_entry_checker
// Watches the index and color streams and the register port, computes the
// expected color for every accepted index and compares it field by field with
// the colors that come out, in order.
// ----------------------------------------------------------------------------
module hsv_color_lut_entry_checker import hsvl_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [23:0]           out_tdata,
  input  logic                  out_tuser,
  output int                    errors,
  output int                    pending
);

  cfg_t cur;
  pix_t color_q[$];

  function automatic logic [31:0] gain_sat(logic [31:0] ch, logic [9:0] g);
    logic [31:0] x;
    x = (ch * g) >> 8;
    return (x > 255) ? 32'd255 : x;
  endfunction

  function automatic pix_t color_of(logic [7:0] idx, cfg_t c);
    longint hs, hue, v, h6, frac, p, q, t, rr, gg, bb;
    logic [31:0] r, g, b, total;
    pix_t px;
    hs = longint'(idx) * longint'(c.hue_step) + longint'(c.hue_bias);
    hue = (hs < 0) ? 0 : (hs & 64'hFFFF);
    v = 0;
    if (idx > c.value_floor) begin
      v = (longint'(idx - c.value_floor) * 65536) / ENTRIES;
      if (v > 65535) v = 65535;
    end
    h6 = hue * 6;
    frac = h6 & 64'hFFFF;
    p = (v * (65536 - 64881)) >> 16;
    q = (v * (65536 - ((64881 * frac) >> 16))) >> 16;
    t = (v * (65536 - ((64881 * (65536 - frac)) >> 16))) >> 16;
    case (h6 >> 16)
      0: begin rr = v; gg = t; bb = p; end
      1: begin rr = q; gg = v; bb = p; end
      2: begin rr = p; gg = v; bb = t; end
      3: begin rr = p; gg = q; bb = v; end
      4: begin rr = t; gg = p; bb = v; end
      default: begin rr = v; gg = p; bb = q; end
    endcase
    r = gain_sat(32'((rr * 127) >> 16), c.red_gain);
    g = gain_sat(32'((gg * 127) >> 16), c.green_gain);
    b = gain_sat(32'((bb * 127) >> 16), c.blue_gain);
    total = r + g + b;
    px.capped = 1'b0;
    if (total > c.brightness_cap) begin
      r = (r * c.brightness_cap) / total;
      g = (g * c.brightness_cap) / total;
      b = (b * c.brightness_cap) / total;
      px.capped = 1'b1;
    end
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    return px;
  endfunction

  always @(posedge clk) begin
    pix_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      cur.hue_bias <= '0;
      cur.hue_step <= 16'd256;
      cur.value_floor <= '0;
      cur.red_gain <= 10'd256;
      cur.green_gain <= 10'd256;
      cur.blue_gain <= 10'd256;
      cur.brightness_cap <= 10'd765;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_HUE_BIAS:    cur.hue_bias <= cfg_data;
          REG_HUE_STEP:    cur.hue_step <= cfg_data[15:0];
          REG_VALUE_FLOOR: cur.value_floor <= cfg_data[7:0];
          REG_RED_GAIN:    cur.red_gain <= cfg_data[9:0];
          REG_GREEN_GAIN:  cur.green_gain <= cfg_data[9:0];
          REG_BLUE_GAIN:   cur.blue_gain <= cfg_data[9:0];
          REG_BRIGHT_CAP:  cur.brightness_cap <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) color_q.push_back(color_of(in_tdata, cur));
      if (out_tvalid && out_tready) begin
        if (color_q.size() == 0) begin
          $error("unexpected color transaction %h", out_tdata);
          bad++;
        end else begin
          want = color_q.pop_front();
          if (out_tdata[7:0] !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_tdata[7:0]);
            bad++;
          end
          if (out_tdata[15:8] !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_tdata[15:8]);
            bad++;
          end
          if (out_tdata[23:16] !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_tdata[23:16]);
            bad++;
          end
          if (out_tuser !== want.capped) begin
            $error("capped: expected %0d, got %0d", want.capped, out_tuser);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
    pending <= color_q.size();
  end

endmodule

[tb/sv/hsv_color_lut_entry_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_color_lut_entry_tb
// Drives indices under several register settings with random gaps and
// back-pressure; the checker predicts and compares every color.
// ----------------------------------------------------------------------------
module hsv_color_lut_entry_tb import hsvl_pkg::*; ;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // index
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // blue, green, red from MSB down
  logic                  out_tuser;       // capped
  int                    errors;
  int                    pending;
  int                    rx_wait = 0;

  always #5 clk = ~clk;

  hsv_color_lut_entry uut (.*);
  hsv_color_lut_entry_checker chk (.*);

  task automatic send_index(logic [7:0] idx);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= idx;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic random_regs(int mode);
    write_reg(REG_HUE_BIAS, mode == 0 ? 19'h40000 : mode == 1 ? 19'h3FFFF
              : 19'($urandom));
    write_reg(REG_HUE_STEP, CFG_DATA_W'(mode == 0 ? 16'hFFFF : mode == 1 ? 16'h0
              : 16'($urandom)));
    write_reg(REG_VALUE_FLOOR, CFG_DATA_W'(mode == 0 ? 8'hFF : mode == 1 ? 8'h0
              : 8'($urandom_range(0, 80))));
    write_reg(REG_RED_GAIN, CFG_DATA_W'(mode == 0 ? 10'h3FF : mode == 1 ? 10'h0
              : 10'($urandom)));
    write_reg(REG_GREEN_GAIN, CFG_DATA_W'(mode == 0 ? 10'h3FF : mode == 1 ? 10'h0
              : 10'($urandom)));
    write_reg(REG_BLUE_GAIN, CFG_DATA_W'(mode == 0 ? 10'h3FF : mode == 1 ? 10'h0
              : 10'($urandom)));
    write_reg(REG_BRIGHT_CAP, CFG_DATA_W'(mode == 0 ? 10'd0 : mode == 1 ? 10'h3FF
              : $urandom_range(0, 3) == 0 ? 10'($urandom)
              : 10'($urandom_range(0, 765))));
    cfg_we <= 1'b0;
  endtask

  // after each transaction the receiver draws a random wait, often zero, and holds out_tready low until it runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        rx_wait = $urandom_range(0, 2) == 0 ? $urandom_range(0, 7) : 0;
      else if (rx_wait != 0)
        rx_wait = rx_wait - 1;
      out_tready <= (rx_wait == 0);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < 16; k++) send_index(k == 0 ? 8'h00 : k == 1 ? 8'hFF
                                             : 8'(k * 17));
    drain();
    random_regs(0);
    for (int k = 0; k < 4; k++) send_index(k[0] ? 8'hFF : 8'h00);
    drain();
    random_regs(1);
    for (int k = 0; k < 4; k++) send_index(k[0] ? 8'hFF : 8'h80);
    drain();
    for (int ph = 0; ph < 14; ph++) begin
      random_regs(2);
      for (int k = 0; k < 125; k++) send_index(8'($urandom));
      drain();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[hsv_color_lut_entry.f]
design/hsvl_pkg.sv
design/hsvl_front.sv
design/hsvl_fifo.sv
design/hsvl_div.sv
design/hsvl_back.sv
design/hsv_color_lut_entry.sv
tb/sv/hsv_color_lut_entry_checker.sv
tb/sv/hsv_color_lut_entry_tb.sv
